/* sv/srm_pkg.sv */
package srm_pkg;

  localparam int unsigned RegCount = 6;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned XlenW    = 32;
  localparam int unsigned CfgDataW = 9;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdStart = 2'd1,
    CmdStep  = 2'd2
  } cmd_e;

  typedef enum logic [0:0] {
    CfgPointerReg = 1'b0,
    CfgProgramLen = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OpAddr = 4'd0,
    OpAddi = 4'd1,
    OpMulr = 4'd2,
    OpMuli = 4'd3,
    OpBanr = 4'd4,
    OpBani = 4'd5,
    OpBorr = 4'd6,
    OpBori = 4'd7,
    OpSetr = 4'd8,
    OpSeti = 4'd9,
    OpGtir = 4'd10,
    OpGtri = 4'd11,
    OpGtrr = 4'd12,
    OpEqir = 4'd13,
    OpEqri = 4'd14,
    OpEqrr = 4'd15
  } op_e;

  // bit n set where opcode n takes operand A (resp. B) as a register index
  localparam logic [15:0] ReadsAReg = 16'b1101_1001_1111_1111;
  localparam logic [15:0] ReadsBReg = 16'b1011_0100_0101_0101;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        load_address;
    logic [3:0]        opcode;
    logic [15:0]       operand_a;
    logic [15:0]       operand_b;
    logic [2:0]        operand_c;
    logic signed [31:0] start_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        next_pointer;
    logic               halted;
    logic signed [31:0] register_zero;
    logic               bad_register;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  operand_c;
  } instr_t;

  localparam int unsigned InstrW = $bits(instr_t);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StFetch = 4'b0010,
    StExec  = 4'b0100,
    StResp  = 4'b1000
  } state_e;

endpackage

/* sv/six_register_machine_step.sv */
// Six-register machine, one instruction per step transaction.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries load, start and
// step commands; every accepted transaction yields exactly one result on the
// output channel (out_valid_o/out_ready_i, out_data_o).
// Configuration writes (cfg_valid_i/cfg_ready_o) set the pointer register
// (index 0) and the program length (index 1); cfg_ready_o is always high.
// A load, a start or a step while halted goes straight to the response stage.
// The step path is one program store read, one register file read, then the
// register write back; one item is worked at a time.
// The result sits in an output register: while it waits for out_ready_i the
// next transaction is accepted and executed, and its result then holds in
// the response stage until the output register frees up.
// Reset clears the registers, the pointer and both configuration registers;
// the program store contents are undefined until loaded. No clearing pass.
module six_register_machine_step #(
  parameter int unsigned PROGRAM_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  srm_pkg::in_item_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output srm_pkg::out_item_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [0:0]           cfg_index_i,
  input  logic [srm_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned AddrW = (PROGRAM_DEPTH > 1) ? $clog2(PROGRAM_DEPTH) : 1;
  localparam logic [31:0] DepthW = 32'(PROGRAM_DEPTH);
  localparam int unsigned RegCount = srm_pkg::RegCount;
  localparam int unsigned RegIdxW = srm_pkg::RegIdxW;
  localparam logic [RegIdxW-1:0] RegLimit = RegIdxW'(RegCount);

  srm_pkg::state_e state_q, state_d;
  logic [31:0]          ip_q, ip_d;
  logic [RegIdxW-1:0]   ptr_q;
  logic [8:0]           len_q;
  logic [RegCount-1:0]  valid_q, valid_d;
  logic [31:0]          r0_q, r0_d;
  srm_pkg::instr_t      instr_q, instr_d;
  logic                 bad_q, bad_d;
  logic                 out_valid_q;
  srm_pkg::out_item_t   out_q;

  logic                 in_fire, out_free, mirrored, running;
  logic [31:0]          eff_len;

  // program store
  logic                 ps_we;
  logic [AddrW-1:0]     ps_waddr;
  srm_pkg::instr_t      ps_wdata, ps_rdata;
  logic [srm_pkg::InstrW-1:0] ps_rdata_raw;
  logic [16:0]          load_addr_ext;

  // register file, two read copies written alike
  logic                 rf_we;
  logic [RegIdxW-1:0]   rf_waddr;
  logic [31:0]          rf_wdata;
  logic [RegIdxW-1:0]   rf_raddr_a, rf_raddr_b;
  logic [31:0]          rf_rdata_a, rf_rdata_b;

  // execute
  srm_pkg::op_e         op;
  logic [RegIdxW-1:0]   a_idx, b_idx, c_idx;
  logic [31:0]          ra, rb, imm_a, imm_b, mul_rhs, prod, val, ip_base;
  logic                 fetch_bad;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == srm_pkg::StIdle);
  assign cfg_ready_o = 1'b1;
  assign mirrored = (ptr_q < RegLimit);
  assign eff_len = (32'(len_q) > DepthW) ? DepthW : 32'(len_q);
  assign running = (ip_q < eff_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      len_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (srm_pkg::cfg_idx_e'(cfg_index_i))
        srm_pkg::CfgPointerReg: ptr_q <= cfg_data_i[RegIdxW-1:0];
        srm_pkg::CfgProgramLen: len_q <= cfg_data_i;
      endcase
    end
  end

  assign load_addr_ext = {9'd0, in_data_i.load_address};
  assign ps_we    = in_fire && (in_data_i.command == srm_pkg::CmdLoad) &&
                    (32'(in_data_i.load_address) < DepthW);
  assign ps_waddr = load_addr_ext[AddrW-1:0];
  assign ps_wdata = '{opcode:    in_data_i.opcode,
                      operand_a: in_data_i.operand_a,
                      operand_b: in_data_i.operand_b,
                      operand_c: in_data_i.operand_c};
  assign ps_rdata = srm_pkg::instr_t'(ps_rdata_raw);

  srm_ram #(
    .Width (srm_pkg::InstrW),
    .Depth (PROGRAM_DEPTH)
  ) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (ps_we),
    .waddr_i (ps_waddr),
    .wdata_i (ps_wdata),
    .raddr_i (ip_q[AddrW-1:0]),
    .rdata_o (ps_rdata_raw)
  );

  assign rf_raddr_a = ps_rdata.operand_a[RegIdxW-1:0];
  assign rf_raddr_b = ps_rdata.operand_b[RegIdxW-1:0];

  srm_ram #(
    .Width (32),
    .Depth (RegCount)
  ) u_reg_ram_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr_a),
    .rdata_o (rf_rdata_a)
  );

  srm_ram #(
    .Width (32),
    .Depth (RegCount)
  ) u_reg_ram_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .raddr_i (rf_raddr_b),
    .rdata_o (rf_rdata_b)
  );

  assign fetch_bad = (srm_pkg::ReadsAReg[ps_rdata.opcode] &&
                      (ps_rdata.operand_a >= 16'(RegCount))) ||
                     (srm_pkg::ReadsBReg[ps_rdata.opcode] &&
                      (ps_rdata.operand_b >= 16'(RegCount))) ||
                     (ps_rdata.operand_c >= 3'(RegCount));

  // operand values: the bound register reads as the pointer, unwritten ones as zero
  assign op    = srm_pkg::op_e'(instr_q.opcode);
  assign a_idx = instr_q.operand_a[RegIdxW-1:0];
  assign b_idx = instr_q.operand_b[RegIdxW-1:0];
  assign c_idx = instr_q.operand_c;
  assign imm_a = {16'd0, instr_q.operand_a};
  assign imm_b = {16'd0, instr_q.operand_b};
  assign ra = (mirrored && (a_idx == ptr_q)) ? ip_q :
              (valid_q[a_idx] ? rf_rdata_a : 32'd0);
  assign rb = (mirrored && (b_idx == ptr_q)) ? ip_q :
              (valid_q[b_idx] ? rf_rdata_b : 32'd0);
  assign mul_rhs = (op == srm_pkg::OpMuli) ? imm_b : rb;
  assign prod    = ra * mul_rhs;

  always_comb begin
    unique case (op)
      srm_pkg::OpAddr: val = ra + rb;
      srm_pkg::OpAddi: val = ra + imm_b;
      srm_pkg::OpMulr: val = prod;
      srm_pkg::OpMuli: val = prod;
      srm_pkg::OpBanr: val = ra & rb;
      srm_pkg::OpBani: val = ra & imm_b;
      srm_pkg::OpBorr: val = ra | rb;
      srm_pkg::OpBori: val = ra | imm_b;
      srm_pkg::OpSetr: val = ra;
      srm_pkg::OpSeti: val = imm_a;
      srm_pkg::OpGtir: val = {31'd0, $signed(imm_a) > $signed(rb)};
      srm_pkg::OpGtri: val = {31'd0, $signed(ra) > $signed(imm_b)};
      srm_pkg::OpGtrr: val = {31'd0, $signed(ra) > $signed(rb)};
      srm_pkg::OpEqir: val = {31'd0, imm_a == rb};
      srm_pkg::OpEqri: val = {31'd0, ra == imm_b};
      srm_pkg::OpEqrr: val = {31'd0, ra == rb};
    endcase
  end

  assign ip_base = (mirrored && !bad_q && (c_idx == ptr_q)) ? val : ip_q;

  always_comb begin
    state_d  = state_q;
    ip_d     = ip_q;
    valid_d  = valid_q;
    r0_d     = r0_q;
    instr_d  = instr_q;
    bad_d    = bad_q;
    rf_we    = 1'b0;
    rf_waddr = '0;
    rf_wdata = '0;
    unique case (state_q)
      srm_pkg::StIdle: begin
        if (in_fire) begin
          bad_d   = 1'b0;
          state_d = srm_pkg::StResp;
          if (in_data_i.command == srm_pkg::CmdStart) begin
            rf_we    = 1'b1;
            rf_waddr = '0;
            rf_wdata = in_data_i.start_value;
            valid_d  = RegCount'(1);
            r0_d     = in_data_i.start_value;
            ip_d     = '0;
          end else if ((in_data_i.command == srm_pkg::CmdStep) && running) begin
            state_d = srm_pkg::StFetch;
          end
        end
      end
      srm_pkg::StFetch: begin
        // mirror the pointer into the bound register
        instr_d = ps_rdata;
        bad_d   = fetch_bad;
        if (mirrored) begin
          rf_we          = 1'b1;
          rf_waddr       = ptr_q;
          rf_wdata       = ip_q;
          valid_d[ptr_q] = 1'b1;
          if (ptr_q == '0) begin
            r0_d = ip_q;
          end
        end
        state_d = srm_pkg::StExec;
      end
      srm_pkg::StExec: begin
        if (!bad_q) begin
          rf_we          = 1'b1;
          rf_waddr       = c_idx;
          rf_wdata       = val;
          valid_d[c_idx] = 1'b1;
          if (c_idx == '0) begin
            r0_d = val;
          end
        end
        ip_d    = ip_base + 32'd1;
        state_d = srm_pkg::StResp;
      end
      srm_pkg::StResp: begin
        if (out_free) begin
          state_d = srm_pkg::StIdle;
        end
      end
      default: state_d = srm_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srm_pkg::StIdle;
      ip_q        <= '0;
      valid_q     <= '0;
      r0_q        <= '0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ip_q    <= ip_d;
      valid_q <= valid_d;
      r0_q    <= r0_d;
      bad_q   <= bad_d;
      if ((state_q == srm_pkg::StResp) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    instr_q <= instr_d;
    if ((state_q == srm_pkg::StResp) && out_free) begin
      out_q.next_pointer  <= ip_q;
      out_q.halted        <= !running;
      out_q.register_zero <= r0_q;
      out_q.bad_register  <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/srm_ram.sv */
module srm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* test/six_register_machine_step_test.sv */
module six_register_machine_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = 256;
  localparam int unsigned ItemTarget = 1250;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 8;
  localparam logic [1:0] CmdUnknown = 2'd3;

  class srm_scoreboard;
    bit [31:0] regs [srm_pkg::RegCount];
    bit [31:0] ip;
    srm_pkg::instr_t store [StoreDepth];
    bit [2:0] ptr_sel;
    bit [8:0] prog_len;
    srm_pkg::out_item_t pending [$];
    int errors;
    int results_seen;
    int steps_run;
    int halted_steps;
    int bad_steps;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (store[i]) store[i] = '0;
      ip = '0;
      ptr_sel = '0;
      prog_len = '0;
      errors = 0;
      results_seen = 0;
      steps_run = 0;
      halted_steps = 0;
      bad_steps = 0;
    endfunction

    function int unsigned span();
      return (prog_len > StoreDepth) ? StoreDepth : int'(prog_len);
    endfunction

    function bit is_halted();
      return ip >= span();
    endfunction

    function bit reads_a(srm_pkg::op_e op);
      return !(op inside {srm_pkg::OpSeti, srm_pkg::OpGtir, srm_pkg::OpEqir});
    endfunction

    function bit reads_b(srm_pkg::op_e op);
      return op inside {srm_pkg::OpAddr, srm_pkg::OpMulr, srm_pkg::OpBanr,
                        srm_pkg::OpBorr, srm_pkg::OpGtir, srm_pkg::OpGtrr,
                        srm_pkg::OpEqir, srm_pkg::OpEqrr};
    endfunction

    function void write_cfg(srm_pkg::cfg_idx_e idx, logic [srm_pkg::CfgDataW-1:0] data);
      if (idx == srm_pkg::CfgPointerReg) ptr_sel = data[2:0];
      else prog_len = data;
    endfunction

    // returns 1 when a register index is out of range and nothing is written
    function bit exec_slot(bit [31:0] pc);
      srm_pkg::instr_t ins;
      srm_pkg::op_e op;
      bit [31:0] ra, rb, ia, ib, v;
      ins = store[pc[7:0]];
      op = srm_pkg::op_e'(ins.opcode);
      if ((reads_a(op) && ins.operand_a > 5) || (reads_b(op) && ins.operand_b > 5) ||
          ins.operand_c > 5) return 1'b1;
      ia = {16'b0, ins.operand_a};
      ib = {16'b0, ins.operand_b};
      ra = (ins.operand_a < srm_pkg::RegCount) ? regs[ins.operand_a[2:0]] : '0;
      rb = (ins.operand_b < srm_pkg::RegCount) ? regs[ins.operand_b[2:0]] : '0;
      case (op)
        srm_pkg::OpAddr: v = ra + rb;
        srm_pkg::OpAddi: v = ra + ib;
        srm_pkg::OpMulr: v = ra * rb;
        srm_pkg::OpMuli: v = ra * ib;
        srm_pkg::OpBanr: v = ra & rb;
        srm_pkg::OpBani: v = ra & ib;
        srm_pkg::OpBorr: v = ra | rb;
        srm_pkg::OpBori: v = ra | ib;
        srm_pkg::OpSetr: v = ra;
        srm_pkg::OpSeti: v = ia;
        srm_pkg::OpGtir: v = {31'b0, $signed(ia) > $signed(rb)};
        srm_pkg::OpGtri: v = {31'b0, $signed(ra) > $signed(ib)};
        srm_pkg::OpGtrr: v = {31'b0, $signed(ra) > $signed(rb)};
        srm_pkg::OpEqir: v = {31'b0, ia == rb};
        srm_pkg::OpEqri: v = {31'b0, ra == ib};
        default: v = {31'b0, ra == rb};
      endcase
      regs[ins.operand_c] = v;
      return 1'b0;
    endfunction

    function void note_input(srm_pkg::in_item_t item);
      bit bad;
      bit mirrored;
      bit [31:0] pc;
      srm_pkg::out_item_t exp;
      bad = 1'b0;
      case (item.command)
        srm_pkg::CmdLoad: begin
          store[item.load_address].opcode = item.opcode;
          store[item.load_address].operand_a = item.operand_a;
          store[item.load_address].operand_b = item.operand_b;
          store[item.load_address].operand_c = item.operand_c;
        end
        srm_pkg::CmdStart: begin
          foreach (regs[i]) regs[i] = '0;
          regs[0] = item.start_value;
          ip = '0;
        end
        srm_pkg::CmdStep: begin
          if (ip < span()) begin
            pc = ip;
            mirrored = ptr_sel < srm_pkg::RegCount;
            if (mirrored) regs[ptr_sel] = pc;
            bad = exec_slot(pc);
            ip = (mirrored && !bad) ? regs[ptr_sel] + 32'd1 : pc + 32'd1;
            steps_run++;
            if (bad) bad_steps++;
          end else begin
            halted_steps++;
          end
        end
        default: ;
      endcase
      exp.next_pointer = ip;
      exp.halted = ip >= span();
      exp.register_zero = regs[0];
      exp.bad_register = bad;
      pending = {pending, exp};
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(srm_pkg::out_item_t got);
      srm_pkg::out_item_t exp;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got.next_pointer !== exp.next_pointer)
        report_mismatch($sformatf("next_pointer %h, want %h", got.next_pointer,
                                  exp.next_pointer));
      if (got.halted !== exp.halted)
        report_mismatch($sformatf("halted %b, want %b", got.halted, exp.halted));
      if (got.register_zero !== exp.register_zero)
        report_mismatch($sformatf("register_zero %h, want %h", got.register_zero,
                                  exp.register_zero));
      if (got.bad_register !== exp.bad_register)
        report_mismatch($sformatf("bad_register %b, want %b", got.bad_register,
                                  exp.bad_register));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid_q = 1'b0;
  logic in_ready;
  srm_pkg::in_item_t in_data_q = '0;
  logic out_valid;
  logic out_ready_q = 1'b0;
  srm_pkg::out_item_t out_data;
  logic cfg_valid_q = 1'b0;
  logic cfg_ready;
  srm_pkg::cfg_idx_e cfg_index_q = srm_pkg::CfgPointerReg;
  logic [srm_pkg::CfgDataW-1:0] cfg_data_q = '0;

  srm_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit sender_calm = 1'b0;
  int phase_count = 0;
  int run_left = 0;
  bit run_high = 1'b0;
  bit ready_next;
  bit slot_loaded [StoreDepth];

  six_register_machine_step u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid_q),
    .in_ready_o (in_ready),
    .in_data_i  (in_data_q),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready_q),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid_q),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index_q),
    .cfg_data_i (cfg_data_q)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               sb.pending.size());
      $display("status: fail");
      $finish;
    end
  end

  // receiver: cycle through four stall patterns, chosen from the cycle count
  always @(posedge clk) begin
    if (out_valid && out_ready_q) sb.check_result(out_data);
    case ((cycle_count / 512) % 4)
      0: ready_next = 1'b1;
      1: ready_next = $urandom_range(0, 1);
      2: ready_next = (cycle_count % 4) == 0;
      default: begin
        if (run_left == 0) begin
          run_high = !run_high;
          run_left = run_high ? $urandom_range(1, 6) : $urandom_range(1, 24);
        end
        run_left--;
        ready_next = run_high;
      end
    endcase
    out_ready_q <= ready_next;
  end

  function automatic srm_pkg::in_item_t rand_item(logic [1:0] cmd);
    srm_pkg::in_item_t item;
    item.command = cmd;
    item.load_address = 8'($urandom_range(0, 255));
    item.opcode = 4'($urandom_range(0, 15));
    item.operand_a = 16'($urandom_range(0, 65535));
    item.operand_b = 16'($urandom_range(0, 65535));
    item.operand_c = 3'($urandom_range(0, 7));
    item.start_value = $urandom;
    return item;
  endfunction

  function automatic logic [15:0] pick_reg();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) return 16'($urandom_range(0, 5));
    if (r < 94) return 16'($urandom_range(6, 7));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] pick_imm();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 15));
    if (r < 48) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic srm_pkg::instr_t make_instr(int unsigned ptr);
    srm_pkg::instr_t ins;
    srm_pkg::op_e op;
    op = srm_pkg::op_e'($urandom_range(0, 15));
    ins.opcode = op;
    ins.operand_a = sb.reads_a(op) ? pick_reg() : pick_imm();
    ins.operand_b = sb.reads_b(op) ? pick_reg() : pick_imm();
    ins.operand_c = ($urandom_range(0, 99) < 93) ? 3'($urandom_range(0, 5)) :
                                                   3'($urandom_range(6, 7));
    // jump through the bound register now and then to build loops
    if (ptr < srm_pkg::RegCount && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 1) begin
        ins.opcode = srm_pkg::OpSeti;
        ins.operand_a = 16'($urandom_range(0, 20));
      end else begin
        ins.opcode = srm_pkg::OpAddi;
        ins.operand_a = 16'(ptr);
        ins.operand_b = 16'($urandom_range(0, 3));
      end
      ins.operand_c = 3'(ptr);
    end
    return ins;
  endfunction

  task automatic send_item(srm_pkg::in_item_t item);
    int gap;
    in_data_q <= item;
    in_valid_q <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(item);
    if (item.command != CmdUnknown) items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      gap = (sender_calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_q <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic load_slot(int unsigned addr, srm_pkg::instr_t ins);
    srm_pkg::in_item_t item;
    item = rand_item(srm_pkg::CmdLoad);
    item.load_address = 8'(addr);
    item.opcode = ins.opcode;
    item.operand_a = ins.operand_a;
    item.operand_b = ins.operand_b;
    item.operand_c = ins.operand_c;
    send_item(item);
    slot_loaded[addr] = 1'b1;
  endtask

  task automatic drain_results();
    if (in_valid_q) in_valid_q <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_config(int unsigned ptr, int unsigned len);
    cfg_index_q <= srm_pkg::CfgPointerReg;
    cfg_data_q <= srm_pkg::CfgDataW'(ptr);
    cfg_valid_q <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_cfg(srm_pkg::CfgPointerReg, srm_pkg::CfgDataW'(ptr));
    cfg_index_q <= srm_pkg::CfgProgramLen;
    cfg_data_q <= srm_pkg::CfgDataW'(len);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_cfg(srm_pkg::CfgProgramLen, srm_pkg::CfgDataW'(len));
    cfg_valid_q <= 1'b0;
  endtask

  task automatic run_directed();
    srm_pkg::in_item_t item;
    srm_pkg::instr_t ins;
    srm_pkg::op_e op;
    send_item(rand_item(srm_pkg::CmdStep));
    send_item('1);
    item = rand_item(srm_pkg::CmdStart);
    item.start_value = 32'h8000_0000;
    send_item(item);
    for (int i = 0; i < 16; i++) begin
      op = srm_pkg::op_e'(i);
      ins.opcode = op;
      ins.operand_a = sb.reads_a(op) ? 16'(i % 6) : 16'hFFFF;
      ins.operand_b = sb.reads_b(op) ? 16'((i + 1) % 6) : ((i % 2 == 1) ? 16'hFFFF : 16'h0);
      ins.operand_c = 3'((i + 2) % 6);
      if (op == srm_pkg::OpBanr) ins.operand_c = 3'd7;
      if (op == srm_pkg::OpGtrr) ins.operand_a = 16'hFFFF;
      if (op == srm_pkg::OpEqir) ins.operand_b = 16'd6;
      load_slot(i, ins);
    end
    ins = '1;
    load_slot(StoreDepth - 1, ins);
    drain_results();
    write_config(2, 16);
    item = rand_item(srm_pkg::CmdStart);
    item.start_value = 32'h7FFF_FFFF;
    send_item(item);
    repeat (5) send_item(rand_item(srm_pkg::CmdStep));
  endtask

  task automatic run_phase(int phase);
    int unsigned ptr, len, span_n, max_steps, roll;
    int steps_left, halted_extra;
    srm_pkg::in_item_t item;
    case (phase)
      0: begin ptr = 0; len = $urandom_range(1, 12); end
      1: begin ptr = 5; len = StoreDepth; end
      2: begin ptr = 7; len = 8; end
      3: begin ptr = $urandom_range(0, 5); len = 511; end
      default: begin
        ptr = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
        roll = $urandom_range(0, 19);
        if (roll == 0) len = 0;
        else if (roll == 1) len = StoreDepth;
        else if (roll == 2) len = $urandom_range(StoreDepth + 1, 511);
        else len = $urandom_range(1, 16);
      end
    endcase
    span_n = (len > StoreDepth) ? StoreDepth : len;
    sender_calm = $urandom_range(0, 3) == 0;
    for (int s = 0; s < span_n; s++)
      if (span_n <= 32 || !slot_loaded[s] || $urandom_range(0, 15) == 0)
        load_slot(s, make_instr(ptr));
    drain_results();
    write_config(ptr, len);
    repeat ($urandom_range(2, 6)) begin
      item = rand_item(srm_pkg::CmdStart);
      case ($urandom_range(0, 7))
        0: item.start_value = 32'h8000_0000;
        1: item.start_value = 32'h7FFF_FFFF;
        2: item.start_value = $urandom_range(0, 10);
        default: ;
      endcase
      send_item(item);
      max_steps = $urandom_range(1, (span_n * 3 + 8 > 60) ? 60 : span_n * 3 + 8);
      steps_left = max_steps;
      halted_extra = 0;
      while (steps_left > 0 && halted_extra < 2) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          send_item(rand_item(CmdUnknown));
        end else if (roll < 8) begin
          item = rand_item(srm_pkg::CmdLoad);
          send_item(item);
          slot_loaded[item.load_address] = 1'b1;
        end else if (roll < 10) begin
          drain_results();
        end else if (roll < 11) begin
          send_item(rand_item(srm_pkg::CmdStart));
        end
        send_item(rand_item(srm_pkg::CmdStep));
        steps_left--;
        if (sb.is_halted()) halted_extra++;
      end
    end
    phase_count++;
  endtask

  initial begin
    foreach (slot_loaded[i]) slot_loaded[i] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    while (items_sent < ItemTarget) run_phase(phase_count);
    drain_results();
    if (sb.pending.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    $display("covered %0d transactions over %0d config phases, %0d results checked",
             items_sent, phase_count, sb.results_seen);
    $display("steps: %0d executed, %0d on a halted machine, %0d with a bad register",
             sb.steps_run, sb.halted_steps, sb.bad_steps);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/srm_pkg.sv
sv/srm_ram.sv
sv/six_register_machine_step.sv
test/six_register_machine_step_test.sv
